@@ src/ipm_pkg.sv @@
// Shared types, constants and the prefix mask function of the IPv4 prefix match table.
// Used by ipm_ctrl, ipm_datapath and ipv4_prefix_match_table; depends on nothing.
package ipm_pkg;

    localparam int ADDR_W   = 32;
    localparam int PREFIX_W = 6;
    localparam int INDEX_W  = 6;
    localparam int CFG_W    = 7;

    localparam logic [PREFIX_W-1:0] FULL_PREFIX = 6'd32;

    // Item function codes.
    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_SCAN = 2'b10
    } ipm_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic wr_en;    // store the entry carried by the accepted word
        logic start;    // latch the query address and restart the scan
        logic advance;  // move the scan pipeline one step
        logic finish;   // emit the closing result of the query
    } ipm_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_free;   // output register can take a result this cycle
        logic scan_done;  // all entries read and compared
    } ipm_status_t;

    // Mask with ones in the top p bits; zero length gives no ones, 32 or more gives all.
    function automatic logic [ADDR_W-1:0] prefix_mask(input logic [PREFIX_W-1:0] p);
        logic [ADDR_W-1:0] m;
        if (p == '0)
        begin
            m = '0;
        end
        else if (p >= FULL_PREFIX)
        begin
            m = '1;
        end
        else
        begin
            m = ~({ADDR_W{1'b1}} >> p);
        end
        return m;
    endfunction

endpackage

@@ src/ipm_ctrl.sv @@
// Controller state machine of the IPv4 prefix match table.
// Depends on ipm_pkg for the state encoding and the command and status structs.
module ipm_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 func,
    output logic                 in_stall,
    input  ipm_pkg::ipm_status_t status,
    output ipm_pkg::ipm_cmd_t    cmd
);
    import ipm_pkg::*;

    ipm_state_t state_reg;
    ipm_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        in_stall    = 1'b1;
        cmd         = '0;
        case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    if (func == FUNC_QUERY)
                    begin
                        cmd.start  = 1'b1;
                        state_next = ST_SCAN;
                    end
                    else
                    begin
                        cmd.wr_en = 1'b1;
                    end
                end
            end
            ST_SCAN:
            begin
                if (status.out_free)
                begin
                    if (status.scan_done)
                    begin
                        cmd.finish = 1'b1;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        cmd.advance = 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

@@ src/ipm_datapath.sv @@
// Datapath of the IPv4 prefix match table: entry memory, scan counter, compare stage,
// pending match and output register. Depends on ipm_pkg.
module ipm_datapath #(
    parameter int TABLE_DEPTH = 64
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  ipm_pkg::ipm_cmd_t             cmd,
    output ipm_pkg::ipm_status_t          status,
    input  logic                          cfg_valid,
    input  logic [ipm_pkg::CFG_W-1:0]     cfg_data,
    input  logic [ipm_pkg::INDEX_W-1:0]   entry_index,
    input  logic [ipm_pkg::ADDR_W-1:0]    address,
    input  logic [ipm_pkg::PREFIX_W-1:0]  prefix_len,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic                          hit,
    output logic [ipm_pkg::INDEX_W-1:0]   match_index,
    output logic                          last
);
    import ipm_pkg::*;

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    // Entry storage, contents undefined until written.
    logic [ADDR_W-1:0]   net_mem [TABLE_DEPTH];
    logic [PREFIX_W-1:0] pfx_mem [TABLE_DEPTH];

    logic [CFG_W-1:0]    entries_in_use_reg;
    logic [CW-1:0]       count_reg;
    logic [CW-1:0]       scan_idx_reg;
    logic [ADDR_W-1:0]   query_addr_reg;

    logic [ADDR_W-1:0]   rd_net_reg;
    logic [PREFIX_W-1:0] rd_pfx_reg;
    logic [AW-1:0]       cmp_idx_reg;
    logic                cmp_valid_reg;

    logic                pend_valid_reg;
    logic [AW-1:0]       pend_idx_reg;

    logic                out_valid_reg;
    logic                out_hit_reg;
    logic [INDEX_W-1:0]  out_idx_reg;
    logic                out_last_reg;

    logic                wr_ok;
    logic [PREFIX_W-1:0] plen_sat;
    logic                rd_en;
    logic [ADDR_W-1:0]   cmp_mask;
    logic                cmp_hit;
    logic                out_free;
    logic                out_load;
    logic                out_hit_next;
    logic [INDEX_W-1:0]  out_idx_next;
    logic                out_last_next;
    logic [CW-1:0]       count_next;

    assign wr_ok    = cmd.wr_en && ({1'b0, entry_index} < (INDEX_W + 1)'(TABLE_DEPTH));
    assign plen_sat = (prefix_len > FULL_PREFIX) ? FULL_PREFIX : prefix_len;
    assign rd_en    = cmd.advance && (scan_idx_reg < count_reg);
    assign cmp_mask = prefix_mask(rd_pfx_reg);
    assign cmp_hit  = cmp_valid_reg
                      && ((rd_net_reg & cmp_mask) == (query_addr_reg & cmp_mask));
    assign out_free = !out_valid_reg || !out_stall;

    assign count_next = (entries_in_use_reg > CFG_W'(TABLE_DEPTH))
                        ? CW'(TABLE_DEPTH) : CW'(entries_in_use_reg);

    assign status.out_free  = out_free;
    assign status.scan_done = (scan_idx_reg >= count_reg) && !cmp_valid_reg;

    // A new match pushes the previous one out with last clear; the closing
    // result carries whatever match is still pending, or a miss.
    always_comb
    begin
        out_load      = 1'b0;
        out_hit_next  = 1'b1;
        out_idx_next  = INDEX_W'(pend_idx_reg);
        out_last_next = 1'b0;
        if (cmd.finish)
        begin
            out_load      = 1'b1;
            out_hit_next  = pend_valid_reg;
            out_idx_next  = pend_valid_reg ? INDEX_W'(pend_idx_reg) : '0;
            out_last_next = 1'b1;
        end
        else if (cmd.advance && cmp_hit && pend_valid_reg)
        begin
            out_load = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_ok)
        begin
            net_mem[entry_index[AW-1:0]] <= address;
            pfx_mem[entry_index[AW-1:0]] <= plen_sat;
        end
        if (rd_en)
        begin
            rd_net_reg  <= net_mem[scan_idx_reg[AW-1:0]];
            rd_pfx_reg  <= pfx_mem[scan_idx_reg[AW-1:0]];
            cmp_idx_reg <= scan_idx_reg[AW-1:0];
        end
        if (cmd.start)
        begin
            query_addr_reg <= address;
        end
        if (cmd.advance && cmp_hit)
        begin
            pend_idx_reg <= cmp_idx_reg;
        end
        if (out_load)
        begin
            out_hit_reg  <= out_hit_next;
            out_idx_reg  <= out_idx_next;
            out_last_reg <= out_last_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entries_in_use_reg <= '0;
            count_reg          <= '0;
            scan_idx_reg       <= '0;
            cmp_valid_reg      <= 1'b0;
            pend_valid_reg     <= 1'b0;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                entries_in_use_reg <= cfg_data;
            end
            if (cmd.start)
            begin
                count_reg      <= count_next;
                scan_idx_reg   <= '0;
                cmp_valid_reg  <= 1'b0;
                pend_valid_reg <= 1'b0;
            end
            else if (cmd.advance)
            begin
                cmp_valid_reg <= rd_en;
                if (rd_en)
                begin
                    scan_idx_reg <= scan_idx_reg + 1'b1;
                end
                if (cmp_hit)
                begin
                    pend_valid_reg <= 1'b1;
                end
            end
            else if (cmd.finish)
            begin
                pend_valid_reg <= 1'b0;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid   = out_valid_reg;
    assign hit         = out_hit_reg;
    assign match_index = out_idx_reg;
    assign last        = out_last_reg;

endmodule

@@ src/ipv4_prefix_match_table.sv @@
// Top level of the IPv4 prefix match table: controller plus datapath.
// Depends on ipm_pkg, ipm_ctrl and ipm_datapath.

// The block holds up to TABLE_DEPTH IPv4 networks, each an address with a prefix
// length. A write word (func = 0) stores one entry; slots at or beyond TABLE_DEPTH
// are ignored and prefix lengths above 32 are stored as 32. A query word (func = 1)
// scans entries 0 to entries_in_use - 1 (at most TABLE_DEPTH) and returns, in
// ascending order, one result word for every entry whose network matches the
// queried address under that entry's prefix mask, with last set on the final word.
// A query with no match returns a single word with hit clear, match_index zero and
// last set. The single read port of the entry memory delivers one entry per cycle
// while the output side does not stall, followed by one compare stage and the
// closing result. Stalls on the output hold the scan. Input is stalled while a
// query scans; the last result may still wait in the output register while the
// next word is taken. Entries must be written before any query scans them.
// entries_in_use is to be written through the configuration channel only while
// the block is idle; the block itself does not enforce this.
module ipv4_prefix_match_table #(
    parameter int TABLE_DEPTH = 64
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // Configuration channel: entries_in_use.
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [ipm_pkg::CFG_W-1:0]     cfg_data,
    // Input channel.
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          func,
    input  logic [ipm_pkg::INDEX_W-1:0]   entry_index,
    input  logic [ipm_pkg::ADDR_W-1:0]    address,
    input  logic [ipm_pkg::PREFIX_W-1:0]  prefix_len,
    // Result channel.
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic                          hit,
    output logic [ipm_pkg::INDEX_W-1:0]   match_index,
    output logic                          last
);
    import ipm_pkg::*;

    ipm_cmd_t    cmd;
    ipm_status_t status;

    // The register is a plain flop, so a write is always taken.
    assign cfg_ready = 1'b1;

    ipm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .func     (func),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    ipm_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .cfg_valid   (cfg_valid),
        .cfg_data    (cfg_data),
        .entry_index (entry_index),
        .address     (address),
        .prefix_len  (prefix_len),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .hit         (hit),
        .match_index (match_index),
        .last        (last)
    );

endmodule
